[design/tps_pkg.sv]
package tps_pkg;

  localparam int PRESSURE_BITS = 16;

  localparam logic [15:0] PRESS_MASK = (PRESSURE_BITS >= 16) ? 16'hFFFF :
                                       16'((32'd1 << PRESSURE_BITS) - 32'd1);
  localparam logic [40:0] PRESS_MAX = (41'd1 << PRESSURE_BITS) - 41'd1;

  typedef enum logic [2:0] {
    MODE_MANUAL    = 3'd0,
    MODE_RAMP      = 3'd1,
    MODE_REGULATE  = 3'd2,
    MODE_OFF       = 3'd3,
    MODE_PASSIVATE = 3'd4,
    MODE_GABORT    = 3'd5,
    MODE_FABORT    = 3'd6
  } mode_t;

  localparam logic [2:0] CMD_PRESS  = 3'd1;
  localparam logic [2:0] CMD_ABORT  = 3'd2;
  localparam logic [2:0] CMD_PASSIV = 3'd3;
  localparam logic [2:0] CMD_RESET  = 3'd4;

  localparam logic [7:0] PRESS_ON  = 8'd1;
  localparam logic [7:0] PRESS_OFF = 8'd0;

  localparam logic [1:0] BALL_NONE  = 2'd0;
  localparam logic [1:0] BALL_CLOSE = 2'd1;
  localparam logic [1:0] BALL_OPEN  = 2'd2;
  localparam logic [1:0] BALL_CTRL  = 2'd3;

  localparam logic [2:0] REG_SET_PRESSURE = 3'd0;
  localparam logic [2:0] REG_EXIT_RATIO   = 3'd1;
  localparam logic [2:0] REG_BYPASS_EN    = 3'd2;
  localparam logic [2:0] REG_BYPASS_DELAY = 3'd3;
  localparam logic [2:0] REG_COMMS_DELAY  = 3'd4;
  localparam logic [2:0] REG_ABORT_DELAY  = 3'd5;
  localparam logic [2:0] REG_RAMP_RATE    = 3'd6;

  typedef struct packed {
    mode_t       state;
    logic        changed;
    logic        safety;
    logic        vent;
    logic [1:0]  ball;
    logic        creset;
    logic [15:0] base;
    logic [31:0] dt;
  } seq_word_t;

endpackage

[design/tps_seq.sv]
module tps_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [2:0]          cmd_kind,
  input  logic [7:0]          cmd_value,
  input  logic [15:0]         tank_pressure,
  input  logic [31:0]         now_ms,
  input  logic [15:0]         setp,
  input  logic [31:0]         exit_prod,
  input  logic                bypass_enable,
  input  logic [31:0]         bypass_delay_ms,
  input  logic [31:0]         comms_loss_delay_ms,
  input  logic [31:0]         abort_flight_delay_ms,
  output tps_pkg::seq_word_t  res
);
  import tps_pkg::*;

  mode_t       mode;
  mode_t       mode_next;
  logic [31:0] ramp_entry_time;
  logic [31:0] off_entry_time;
  logic [31:0] abort_entry_time;
  logic [15:0] ramp_start_pressure;
  logic        safety_latch;
  logic        vent_latch;
  logic        safety_next;
  logic        vent_next;
  logic [15:0] tank_m;
  logic        changed;
  logic        exit_met;
  logic [31:0] ramp_dt;
  logic [31:0] off_dt;
  logic [31:0] abort_dt;

  assign tank_m   = tank_pressure & PRESS_MASK;
  assign exit_met = {1'b0, tank_m, 15'd0} >= exit_prod;
  assign ramp_dt  = now_ms - ramp_entry_time;
  assign off_dt   = now_ms - off_entry_time;
  assign abort_dt = now_ms - abort_entry_time;

  always_comb begin
    mode_next = mode;
    case (mode)
      MODE_MANUAL: begin
        if (cmd_kind == CMD_PRESS && cmd_value == PRESS_ON) mode_next = MODE_RAMP;
      end
      MODE_RAMP: begin
        if (cmd_kind == CMD_ABORT) mode_next = MODE_GABORT;
        else if (bypass_enable && ramp_dt >= bypass_delay_ms) mode_next = MODE_REGULATE;
        else if (exit_met) mode_next = MODE_REGULATE;
      end
      MODE_REGULATE: begin
        if (cmd_kind == CMD_ABORT) mode_next = MODE_GABORT;
        else if (cmd_kind == CMD_PRESS && cmd_value == PRESS_OFF) mode_next = MODE_OFF;
      end
      MODE_OFF: begin
        if (cmd_kind == CMD_ABORT) mode_next = MODE_FABORT;
        else if (cmd_kind == CMD_PASSIV) mode_next = MODE_PASSIVATE;
        else if (off_dt >= comms_loss_delay_ms) mode_next = MODE_PASSIVATE;
      end
      MODE_PASSIVATE, MODE_GABORT: begin
        if (cmd_kind == CMD_RESET) mode_next = MODE_MANUAL;
      end
      MODE_FABORT: begin
        if (abort_dt >= abort_flight_delay_ms) mode_next = MODE_PASSIVATE;
      end
      default: mode_next = MODE_GABORT;
    endcase
  end

  assign changed = mode_next != mode;

  always_comb begin
    safety_next = safety_latch;
    vent_next   = vent_latch;
    res         = '0;
    res.state   = mode_next;
    res.changed = changed;
    res.ball    = BALL_NONE;
    if (changed) begin
      case (mode_next)
        MODE_RAMP: begin
          safety_next = 1'b1;
          vent_next   = 1'b0;
          res.creset  = 1'b1;
        end
        MODE_OFF: begin
          safety_next = 1'b0;
          vent_next   = 1'b0;
          res.ball    = BALL_CLOSE;
        end
        MODE_GABORT: begin
          safety_next = 1'b0;
          vent_next   = 1'b1;
          res.ball    = BALL_CLOSE;
        end
        MODE_FABORT: begin
          safety_next = 1'b0;
          res.ball    = BALL_CLOSE;
        end
        MODE_REGULATE: begin
          res.creset = 1'b1;
        end
        default: ;
      endcase
    end
    case (mode_next)
      MODE_RAMP: begin
        res.ball = BALL_CTRL;
        res.base = changed ? tank_m : ramp_start_pressure;
        res.dt   = changed ? 32'd0 : ramp_dt;
      end
      MODE_REGULATE: begin
        res.ball    = BALL_CTRL;
        res.base    = setp;
        safety_next = 1'b1;
        vent_next   = 1'b0;
      end
      MODE_PASSIVATE: begin
        res.ball    = BALL_OPEN;
        safety_next = 1'b1;
        vent_next   = 1'b1;
      end
      default: ;
    endcase
    res.safety = safety_next;
    res.vent   = vent_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                <= MODE_MANUAL;
      ramp_entry_time     <= '0;
      off_entry_time      <= '0;
      abort_entry_time    <= '0;
      ramp_start_pressure <= '0;
      safety_latch        <= 1'b0;
      vent_latch          <= 1'b0;
    end else if (step) begin
      mode         <= mode_next;
      safety_latch <= safety_next;
      vent_latch   <= vent_next;
      if (changed && mode_next == MODE_RAMP) begin
        ramp_entry_time     <= now_ms;
        ramp_start_pressure <= tank_m;
      end
      if (changed && mode_next == MODE_OFF) off_entry_time <= now_ms;
      if (changed && mode_next == MODE_FABORT) abort_entry_time <= now_ms;
    end
  end

endmodule

[design/tps_ref.sv]
module tps_ref (
  input  tps_pkg::seq_word_t  word,
  input  logic [15:0]         ramp_rate,
  output logic [15:0]         target
);
  import tps_pkg::*;

  logic [47:0] prod;
  logic [40:0] sum;

  assign prod = word.dt * ramp_rate;
  assign sum  = {25'd0, word.base} + {1'b0, prod[47:8]};

  always_comb begin
    if (word.ball != BALL_CTRL) target = '0;
    else if (sum > PRESS_MAX) target = PRESS_MAX[15:0];
    else target = sum[15:0];
  end

endmodule

[design/tank_pressurization_sequencer_core.sv]
// Channel | Dir | Handshake         | Word
// s       | in  | s_tvalid/s_tready | tuser: cmd_kind; tdata: cmd_value, tank_pressure, now_ms
// m       | out | m_tvalid/m_tready | tdata: fsm_state ... controller_reset
// cfg     | in  | cfg_we            | cfg_addr selects register, cfg_data value
//
// One word per cycle while m_tready does not stall the output, through these steps:
// Input register, sequencer state update, then reference multiply-add and output register.
// Reset (rst, synchronous) returns the sequencer to manual and loads register defaults.
// Each stage advances when the stage after it is empty or moving; bubbles are absorbed.
// A stalled output keeps s_tready high until all three stages are full.
module tank_pressurization_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // cmd_value[7:0], tank_pressure[23:8], now_ms[55:24]
  input  logic [2:0]  s_tuser,   // cmd_kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // fsm_state[2:0], state_changed[3], safety_open[4],
                                 // vent_open[5], ball_command[7:6], target_pressure[23:8],
                                 // controller_reset[24], zero[31:25]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data
);
  import tps_pkg::*;

  logic [15:0] set_pressure;
  logic [15:0] exit_ratio;
  logic        bypass_enable;
  logic [31:0] bypass_delay_ms;
  logic [31:0] comms_loss_delay_ms;
  logic [31:0] abort_flight_delay_ms;
  logic [15:0] ramp_rate;
  logic [15:0] setp;
  logic [31:0] exit_prod;

  logic        s1_valid;
  logic [2:0]  s1_kind;
  logic [7:0]  s1_value;
  logic [15:0] s1_tank;
  logic [31:0] s1_now;
  logic        s1_ready;

  logic        s2_valid;
  seq_word_t   s2_word;
  logic        s2_ready;
  seq_word_t   seq_res;

  logic        out_ready;
  logic [15:0] target;
  mode_t       out_state;
  logic        out_changed;
  logic        out_safety;
  logic        out_vent;
  logic [1:0]  out_ball;
  logic [15:0] out_target;
  logic        out_creset;

  assign setp      = set_pressure & PRESS_MASK;
  assign out_ready = !m_tvalid || m_tready;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign s_tready  = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_pressure          <= 16'd512;
      exit_ratio            <= 16'd32113;
      bypass_enable         <= 1'b1;
      bypass_delay_ms       <= 32'd5000;
      comms_loss_delay_ms   <= 32'd140000;
      abort_flight_delay_ms <= 32'd10000;
      ramp_rate             <= 16'd3277;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SET_PRESSURE: set_pressure          <= cfg_data[15:0];
        REG_EXIT_RATIO:   exit_ratio            <= cfg_data[15:0];
        REG_BYPASS_EN:    bypass_enable         <= cfg_data[0];
        REG_BYPASS_DELAY: bypass_delay_ms       <= cfg_data;
        REG_COMMS_DELAY:  comms_loss_delay_ms   <= cfg_data;
        REG_ABORT_DELAY:  abort_flight_delay_ms <= cfg_data;
        REG_RAMP_RATE:    ramp_rate             <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    exit_prod <= exit_ratio * setp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s_tvalid;
    end
    if (s1_ready && s_tvalid) begin
      s1_kind  <= s_tuser;
      s1_value <= s_tdata[7:0];
      s1_tank  <= s_tdata[23:8];
      s1_now   <= s_tdata[55:24];
    end
  end

  tps_seq u_seq (
    .clk                   (clk),
    .rst                   (rst),
    .step                  (s1_valid && s2_ready),
    .cmd_kind              (s1_kind),
    .cmd_value             (s1_value),
    .tank_pressure         (s1_tank),
    .now_ms                (s1_now),
    .setp                  (setp),
    .exit_prod             (exit_prod),
    .bypass_enable         (bypass_enable),
    .bypass_delay_ms       (bypass_delay_ms),
    .comms_loss_delay_ms   (comms_loss_delay_ms),
    .abort_flight_delay_ms (abort_flight_delay_ms),
    .res                   (seq_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      s2_word <= seq_res;
    end
  end

  tps_ref u_ref (
    .word      (s2_word),
    .ramp_rate (ramp_rate),
    .target    (target)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= s2_valid;
    end
    if (out_ready && s2_valid) begin
      out_state   <= s2_word.state;
      out_changed <= s2_word.changed;
      out_safety  <= s2_word.safety;
      out_vent    <= s2_word.vent;
      out_ball    <= s2_word.ball;
      out_target  <= target;
      out_creset  <= s2_word.creset;
    end
  end

  assign m_tdata = {7'd0, out_creset, out_target, out_ball, out_vent, out_safety,
                    out_changed, out_state};

  a_target_unused: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_ball != BALL_CTRL |-> out_target == 16'd0)
    else $error("reference not zero without controller drive");

  a_creset_on_change: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_creset |-> out_changed &&
      (out_state == MODE_RAMP || out_state == MODE_REGULATE))
    else $error("controller reset outside ramp or regulate entry");

  a_passivate_valves: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_state == MODE_PASSIVATE |-> out_safety && out_vent &&
      out_ball == BALL_OPEN)
    else $error("passivate without both valves open");

  a_regulate_valves: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_state == MODE_REGULATE |-> out_safety && !out_vent)
    else $error("regulate with wrong valve latches");

  a_ready_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> s1_valid && s2_valid && m_tvalid && !m_tready)
    else $error("input stalled with room in the pipeline");

endmodule
